FILE: rtl/core/dsa_pkg.sv
// Shared types and constants for the debounced status alerter.
// Used by dsa_debounce and debounced_status_alerter; depends on nothing.
package dsa_pkg;

  localparam int unsigned CountW      = 8;
  localparam int unsigned CooldownW   = 16;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned ViewerBitsDef = 8;

  localparam logic [CountW-1:0]    HealthNeededRst   = 8'd3;
  localparam logic [CountW-1:0]    ViewerNeededRst   = 8'd3;
  localparam logic [CountW-1:0]    ExitNeededRst     = 8'd3;
  localparam logic [CooldownW-1:0] CooldownTicksRst  = 16'd0;

  localparam logic [CfgIdxW-1:0] RegHealthNeeded = 2'd0;
  localparam logic [CfgIdxW-1:0] RegViewerNeeded = 2'd1;
  localparam logic [CfgIdxW-1:0] RegExitNeeded   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegCooldown     = 2'd3;

  typedef enum logic [1:0] {
    AlertHealthUp   = 2'd0,
    AlertHealthDown = 2'd1,
    AlertViewers    = 2'd2,
    AlertServerExit = 2'd3
  } alert_kind_e;

endpackage

FILE: rtl/core/dsa_debounce.sv
// Sample-count debouncer for one status signal of configurable width.
// Depends on dsa_pkg for the run counter width.
module dsa_debounce import dsa_pkg::*; #(
  parameter int unsigned Width = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              load_i,
  input  logic [Width-1:0]  sample_i,
  input  logic [CountW-1:0] needed_i,
  output logic [Width-1:0]  stable_d_o,
  output logic              changed_o
);

  logic [Width-1:0]  stable_q, stable_d;
  logic [Width-1:0]  pending_q, pending_d;
  logic [CountW-1:0] run_q, run_d;
  logic [CountW-1:0] limit;
  logic              fire;

  assign limit = (needed_i == '0) ? CountW'(1) : needed_i;

  always_comb begin
    stable_d  = stable_q;
    pending_d = pending_q;
    run_d     = run_q;
    fire      = 1'b0;
    if (load_i) begin
      stable_d  = sample_i;
      pending_d = sample_i;
      run_d     = '0;
    end else begin
      if (sample_i == stable_q) begin
        run_d = '0;
      end else if (sample_i == pending_q) begin
        if (run_q != '1) begin
          run_d = run_q + CountW'(1);
        end
      end else begin
        pending_d = sample_i;
        run_d     = CountW'(1);
      end
      if (run_d >= limit) begin
        fire     = 1'b1;
        stable_d = pending_d;
        run_d    = '0;
      end
    end
  end

  assign changed_o  = fire && (stable_d != stable_q);
  assign stable_d_o = stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q  <= '0;
      pending_q <= '0;
      run_q     <= '0;
    end else if (step_i) begin
      stable_q  <= stable_d;
      pending_q <= pending_d;
      run_q     <= run_d;
    end
  end

endmodule

FILE: rtl/core/debounced_status_alerter.sv
// Top level of the debounced status alerter: config registers, three debouncers,
// the shared alert cooldown and the result group register; uses dsa_pkg and dsa_debounce.
// The results of an item are registered and appear in the cycle after it is accepted.
// One item per cycle while each item raises at most one alert and the output is not stalled;
// an item raising several alerts holds the output, and stalls the input, until its last alert is taken.
// Reset clears all state but the result data and restores the configuration defaults.
module debounced_status_alerter import dsa_pkg::*; #(
  parameter int unsigned VIEWER_BITS = ViewerBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [CfgDataW-1:0]    cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   health_ok_i,
  input  logic                   server_up_i,
  input  logic [VIEWER_BITS-1:0] viewers_now_i,
  input  logic                   stop_asked_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             alert_kind_o,
  output logic [VIEWER_BITS-1:0] stable_viewers_o,
  output logic                   last_alert_o
);

  logic [CountW-1:0]    health_needed_q, viewer_needed_q, exit_needed_q;
  logic [CooldownW-1:0] cooldown_ticks_q;
  logic                 started_q;
  logic [CooldownW-1:0] cooldown_q, cooldown_d;
  logic [CooldownW-1:0] cd_dec, cd_after_h, cd_after_v;
  logic                 in_fire, out_fire, load;

  logic                   health_stable_d, health_chg;
  logic                   server_stable_d, server_chg;
  logic [VIEWER_BITS-1:0] viewers_stable_d;
  logic                   viewers_chg;
  logic                   issue_h, issue_v, issue_s;

  logic [2:0]             mask_q, mask_d, mask_rest;
  logic                   health_up_q;
  logic [VIEWER_BITS-1:0] viewers_q;
  alert_kind_e            kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      health_needed_q  <= HealthNeededRst;
      viewer_needed_q  <= ViewerNeededRst;
      exit_needed_q    <= ExitNeededRst;
      cooldown_ticks_q <= CooldownTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegHealthNeeded: health_needed_q  <= cfg_data_i[CountW-1:0];
        RegViewerNeeded: viewer_needed_q  <= cfg_data_i[CountW-1:0];
        RegExitNeeded:   exit_needed_q    <= cfg_data_i[CountW-1:0];
        RegCooldown:     cooldown_ticks_q <= cfg_data_i[CooldownW-1:0];
        default: ;
      endcase
    end
  end

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign load     = !started_q;

  dsa_debounce #(.Width(1)) u_health (
    .clk_i, .rst_ni,
    .step_i     (in_fire),
    .load_i     (load),
    .sample_i   (health_ok_i),
    .needed_i   (health_needed_q),
    .stable_d_o (health_stable_d),
    .changed_o  (health_chg)
  );

  dsa_debounce #(.Width(VIEWER_BITS)) u_viewers (
    .clk_i, .rst_ni,
    .step_i     (in_fire),
    .load_i     (load),
    .sample_i   (viewers_now_i),
    .needed_i   (viewer_needed_q),
    .stable_d_o (viewers_stable_d),
    .changed_o  (viewers_chg)
  );

  dsa_debounce #(.Width(1)) u_server (
    .clk_i, .rst_ni,
    .step_i     (in_fire),
    .load_i     (load),
    .sample_i   (server_up_i),
    .needed_i   (exit_needed_q),
    .stable_d_o (server_stable_d),
    .changed_o  (server_chg)
  );

  // The cooldown is decremented first, then each alert in turn may issue
  // and reload it, so later alerts of the same item see the reloaded value.
  // A one-bit server change to stopped means it was running before.
  always_comb begin
    cd_dec  = (cooldown_q == '0) ? '0 : cooldown_q - CooldownW'(1);
    issue_h = !load && health_chg && (cd_dec == '0);
    cd_after_h = issue_h ? cooldown_ticks_q : cd_dec;
    issue_v = !load && viewers_chg && (cd_after_h == '0);
    cd_after_v = issue_v ? cooldown_ticks_q : cd_after_h;
    issue_s = !load && server_chg && !server_stable_d &&
              !stop_asked_i && (cd_after_v == '0);
    cooldown_d = issue_s ? cooldown_ticks_q : cd_after_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q  <= 1'b0;
      cooldown_q <= '0;
    end else if (in_fire) begin
      started_q  <= 1'b1;
      cooldown_q <= cooldown_d;
    end
  end

  // Result group: one pending bit per alert, drained lowest bit first.
  always_comb begin
    kind      = AlertHealthUp;
    mask_rest = mask_q;
    if (mask_q[0]) begin
      kind         = health_up_q ? AlertHealthUp : AlertHealthDown;
      mask_rest[0] = 1'b0;
    end else if (mask_q[1]) begin
      kind         = AlertViewers;
      mask_rest[1] = 1'b0;
    end else if (mask_q[2]) begin
      kind         = AlertServerExit;
      mask_rest[2] = 1'b0;
    end
  end

  assign out_valid_o      = |mask_q;
  assign alert_kind_o     = kind;
  assign stable_viewers_o = viewers_q;
  assign last_alert_o     = (mask_rest == '0);
  assign in_ready_o       = !out_valid_o || (out_ready_i && last_alert_o);

  always_comb begin
    mask_d = mask_q;
    if (out_fire) begin
      mask_d = mask_rest;
    end
    if (in_fire) begin
      mask_d = {issue_s, issue_v, issue_h};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      health_up_q <= health_stable_d;
      viewers_q   <= viewers_stable_d;
    end
  end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for debounced_status_alerter: directed and random status samples,
// with an in-bench prediction of the debounced alerts and random stalls on both channels.
// Depends on dsa_pkg and the debounced_status_alerter RTL.
module testbench;
  import dsa_pkg::*;

  localparam int unsigned ViewerBits     = ViewerBitsDef;
  localparam int          IdleSettle     = 4;
  localparam int          PressureCycles = 60;
  localparam int          WatchdogLimit  = 1000;

  typedef struct packed {
    logic                  health_ok;
    logic                  server_up;
    logic [ViewerBits-1:0] viewers_now;
    logic                  stop_asked;
  } status_sample_t;

  typedef struct packed {
    alert_kind_e           kind;
    logic [ViewerBits-1:0] stable_viewers;
    logic                  last;
  } alert_result_t;

  typedef struct packed {
    logic [ViewerBits-1:0] stable;
    logic [ViewerBits-1:0] pending;
    logic [CountW-1:0]     run;
  } debounce_t;

  class alert_scoreboard;
    logic [CountW-1:0]    health_need;
    logic [CountW-1:0]    viewer_need;
    logic [CountW-1:0]    exit_need;
    logic [CooldownW-1:0] cooldown_reload;
    logic                 started;
    debounce_t            health;
    debounce_t            viewers;
    debounce_t            server;
    logic [CooldownW-1:0] cooldown_left;
    alert_result_t        alerts_due[$];
    int                   errors;

    function new();
      health_need     = HealthNeededRst;
      viewer_need     = ViewerNeededRst;
      exit_need       = ExitNeededRst;
      cooldown_reload = CooldownTicksRst;
      started         = 1'b0;
      health          = '0;
      viewers         = '0;
      server          = '0;
      cooldown_left   = '0;
      errors          = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegHealthNeeded: health_need = data[CountW-1:0];
        RegViewerNeeded: viewer_need = data[CountW-1:0];
        RegExitNeeded:   exit_need = data[CountW-1:0];
        RegCooldown:     cooldown_reload = data[CooldownW-1:0];
        default: ;
      endcase
    endfunction

    function bit settle(inout debounce_t d, input logic [ViewerBits-1:0] value,
                        input logic [CountW-1:0] needed);
      logic [CountW-1:0] limit;
      limit = (needed == '0) ? CountW'(1) : needed;
      if (value == d.stable) begin
        d.run = '0;
      end else if (value == d.pending) begin
        if (d.run != '1) d.run = d.run + 1'b1;
      end else begin
        d.pending = value;
        d.run = CountW'(1);
      end
      if (d.run >= limit) begin
        d.stable = d.pending;
        d.run = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit grant_alert();
      if (cooldown_left != '0) return 1'b0;
      cooldown_left = cooldown_reload;
      return 1'b1;
    endfunction

    function int pending_alerts();
      return alerts_due.size();
    endfunction

    function void note_sample(status_sample_t s);
      alert_kind_e           kinds[$];
      alert_result_t         due;
      logic [ViewerBits-1:0] prev;
      logic [ViewerBits-1:0] health_val;
      logic [ViewerBits-1:0] server_val;
      health_val = ViewerBits'(s.health_ok);
      server_val = ViewerBits'(s.server_up);
      if (cooldown_left != '0) cooldown_left = cooldown_left - 1'b1;
      if (!started) begin
        started = 1'b1;
        health  = '{stable: health_val, pending: health_val, run: '0};
        viewers = '{stable: s.viewers_now, pending: s.viewers_now, run: '0};
        server  = '{stable: server_val, pending: server_val, run: '0};
        return;
      end
      prev = health.stable;
      if (settle(health, health_val, health_need) && health.stable != prev) begin
        if (grant_alert()) kinds = {kinds, health.stable[0] ? AlertHealthUp : AlertHealthDown};
      end
      prev = viewers.stable;
      if (settle(viewers, s.viewers_now, viewer_need) && viewers.stable != prev) begin
        if (grant_alert()) kinds = {kinds, AlertViewers};
      end
      prev = server.stable;
      if (settle(server, server_val, exit_need) && prev[0] && !server.stable[0] &&
          !s.stop_asked) begin
        if (grant_alert()) kinds = {kinds, AlertServerExit};
      end
      foreach (kinds[k]) begin
        due = '{kind: kinds[k], stable_viewers: viewers.stable,
                last: (k == kinds.size() - 1)};
        alerts_due = {alerts_due, due};
      end
    endfunction

    function void check_alert(alert_result_t got);
      alert_result_t want;
      if (alerts_due.size() == 0) begin
        $error("alert with no item to explain it: alert_kind %0d stable_viewers %0d",
               got.kind, got.stable_viewers);
        errors++;
        return;
      end
      want = alerts_due.pop_front();
      if (got.kind !== want.kind) begin
        $error("alert_kind: expected %0d, actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.stable_viewers !== want.stable_viewers) begin
        $error("stable_viewers: expected %0d, actual %0d", want.stable_viewers,
               got.stable_viewers);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_alert: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CfgIdxW-1:0]    cfg_idx_i;
  logic [CfgDataW-1:0]   cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  health_ok_i;
  logic                  server_up_i;
  logic [ViewerBits-1:0] viewers_now_i;
  logic                  stop_asked_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [1:0]            alert_kind_o;
  logic [ViewerBits-1:0] stable_viewers_o;
  logic                  last_alert_o;

  alert_scoreboard sb = new();
  bit              tx_calm;
  bit              rx_calm;
  bit              pressure_req;
  int              quiet_cycles;

  debounced_status_alerter #(
    .VIEWER_BITS(ViewerBits)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .health_ok_i     (health_ok_i),
    .server_up_i     (server_up_i),
    .viewers_now_i   (viewers_now_i),
    .stop_asked_i    (stop_asked_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .alert_kind_o    (alert_kind_o),
    .stable_viewers_o(stable_viewers_o),
    .last_alert_o    (last_alert_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(10, 4);
    return $urandom_range(40, 15);
  endfunction

  function automatic logic [ViewerBits-1:0] pick_viewers();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return ViewerBits'($urandom_range(255));
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_alert('{kind: alert_kind_e'(alert_kind_o), stable_viewers: stable_viewers_o,
                         last: last_alert_o});
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("debounced_status_alerter regression: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (pressure_req) begin
        pressure_req = 1'b0;
        stall_left = PressureCycles;
      end
      if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else if (rx_calm || $urandom_range(99) < 70) begin
        out_ready_i = 1'b1;
      end else begin
        out_ready_i = 1'b0;
        stall_left = pick_gap(1'b0);
      end
    end
  end

  task automatic offer_sample(status_sample_t s);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    health_ok_i   = s.health_ok;
    server_up_i   = s.server_up;
    viewers_now_i = s.viewers_now;
    stop_asked_i  = s.stop_asked;
    in_valid_i    = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(s);
    @(negedge clk_i);
  endtask

  task automatic offer_repeat(logic h, logic up, logic [ViewerBits-1:0] v, logic stop, int n);
    repeat (n) offer_sample('{health_ok: h, server_up: up, viewers_now: v, stop_asked: stop});
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (sb.pending_alerts() != 0) @(negedge clk_i);
    repeat (IdleSettle) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(logic [CountW-1:0] health_need, logic [CountW-1:0] viewer_need,
                            logic [CountW-1:0] exit_need, logic [CooldownW-1:0] cooldown);
    wait_idle();
    write_reg(RegHealthNeeded, {8'($urandom_range(255)), health_need});
    write_reg(RegViewerNeeded, {8'($urandom_range(255)), viewer_need});
    write_reg(RegExitNeeded, {8'($urandom_range(255)), exit_need});
    write_reg(RegCooldown, cooldown);
  endtask

  // Signals hold a value for a while and then move, with occasional one-sample glitches; hold_health pins health.
  task automatic random_phase(int count, int span, bit hold_health);
    status_sample_t        s;
    logic                  health_goal;
    logic                  server_goal;
    logic [ViewerBits-1:0] viewers_goal;
    logic                  forced_health;
    health_goal   = sb.health.stable[0];
    server_goal   = sb.server.stable[0];
    viewers_goal  = sb.viewers.stable;
    forced_health = ~sb.health.stable[0];
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(span - 1) == 0) health_goal = ~health_goal;
      if ($urandom_range(span - 1) == 0) server_goal = ~server_goal;
      if ($urandom_range(span - 1) == 0) viewers_goal = pick_viewers();
      s = '{health_ok: health_goal, server_up: server_goal, viewers_now: viewers_goal,
            stop_asked: ($urandom_range(2) == 0)};
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0: s.health_ok = ~s.health_ok;
          1: s.server_up = ~s.server_up;
          default: s.viewers_now = ViewerBits'($urandom_range(255));
        endcase
      end
      if (hold_health) s.health_ok = forced_health;
      offer_sample(s);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegHealthNeeded;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    health_ok_i   = 1'b0;
    server_up_i   = 1'b0;
    viewers_now_i = '0;
    stop_asked_i  = 1'b0;
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    pressure_req  = 1'b0;
    quiet_cycles  = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The first sample only loads; then all three signals change at once.
    offer_repeat(1'b1, 1'b1, 8'd255, 1'b0, 1);
    offer_repeat(1'b0, 1'b0, 8'd0, 1'b0, 3);
    offer_repeat(1'b1, 1'b1, 8'd128, 1'b1, 3);
    // A requested stop and a restart raise nothing.
    offer_repeat(1'b1, 1'b0, 8'd128, 1'b1, 3);
    offer_repeat(1'b1, 1'b1, 8'd128, 1'b0, 3);
    // A glitch back to the stable count restarts the run.
    offer_repeat(1'b1, 1'b1, 8'd5, 1'b0, 1);
    offer_repeat(1'b1, 1'b1, 8'd128, 1'b0, 1);
    offer_repeat(1'b1, 1'b1, 8'd9, 1'b0, 3);
    // A zero threshold acts as one, and the cooldown drops the middle alert.
    set_config(8'd0, 8'd3, 8'd3, 16'd2);
    offer_repeat(1'b0, 1'b1, 8'd9, 1'b0, 1);
    offer_repeat(1'b1, 1'b1, 8'd9, 1'b0, 1);
    offer_repeat(1'b0, 1'b1, 8'd9, 1'b0, 1);

    set_config(8'd0, 8'd1, 8'd2, 16'd0);
    tx_calm      = 1'b1;
    rx_calm      = 1'b1;
    pressure_req = 1'b1;
    random_phase(30, 2, 1'b0);
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    set_config(8'd1, 8'd0, 8'd4, 16'd7);
    random_phase(30, 3, 1'b0);
    set_config(8'd180, 8'd1, 8'd2, 16'd0);
    random_phase(190, 4, 1'b1);
    set_config(8'd1, 8'd2, 8'd1, 16'd1);
    random_phase(25, 3, 1'b0);
    set_config(8'd3, 8'd255, 8'd3, 16'd65535);
    random_phase(20, 5, 1'b0);

    wait_idle();
    repeat (8) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_alerts() == 0) begin
      $display("debounced_status_alerter regression: pass");
    end else begin
      $display("debounced_status_alerter regression: fail");
    end
    $finish;
  end

endmodule
